>>> design/ffra_pkg.sv
// Shared types, constants and helpers for the first-fit range allocator.
// No dependencies; every other design file imports this package.
package ffra_pkg;

  localparam int MAX_FREE_BLOCKS = 16;
  localparam int SLOT_BITS       = 16;
  localparam int IDX_W           = $clog2(MAX_FREE_BLOCKS);
  localparam int CNT_W           = $clog2(MAX_FREE_BLOCKS + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_RANGE_SIZE = '0;

  localparam logic [SLOT_BITS-1:0] RANGE_RESET = SLOT_BITS'(1024);

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_LIST_FULL = 2'd2
  } res_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic        load_req;
    logic        step;
    logic        alloc_take;
    logic        rel_mark;
    logic        rel_commit;
    logic        set_res;
    res_status_t res_code;
  } ffra_cmd_t;

  typedef struct packed {
    logic is_release;
    logic cnt_zero;
    logic scan_end;
    logic alloc_hit;
    logic ins_hit;
    logic list_full;
    logic merge_none;
  } ffra_stat_t;

  function automatic logic [SLOT_BITS-1:0] sat_add(input logic [SLOT_BITS-1:0] a,
                                                   input logic [SLOT_BITS-1:0] b);
    logic [SLOT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SLOT_BITS] ? {SLOT_BITS{1'b1}} : s[SLOT_BITS-1:0];
  endfunction

endpackage

>>> design/first_fit_range_allocator.sv
// Top level of the first-fit range allocator: APB register port and result register.
// Depends on ffra_pkg, ffra_ctrl and ffra_datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | in_valid/in_stall  | cmd, slot_count, release_offset
//   output   | out_valid/out_stall| status, granted_offset, free_slots
//   config   | APB psel/penable   | range_size at byte address 0
//
// An allocate takes an accept step, a scan of the free list at one entry per
// cycle (up to 17 scan steps) and a finish step; a release adds a merge step.
// The worst case is set by the one-entry-per-cycle scan of the free list.
// Synchronous reset restores range_size 1024 and a single free block.
// The result register frees the core: the next request is taken while a
// result still waits under out_stall; the finish step waits only if a
// second result would overwrite an untaken one.
module first_fit_range_allocator import ffra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [SLOT_BITS-1:0]  slot_count,
  input  logic [SLOT_BITS-1:0]  release_offset,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [SLOT_BITS-1:0]  granted_offset,
  output logic [SLOT_BITS-1:0]  free_slots,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ffra_cmd_t            dp_cmd;
  ffra_stat_t           dp_stat;
  logic                 out_ready;
  logic                 out_load;
  logic                 cfg_wr;
  logic                 reg_sel;
  logic [SLOT_BITS-1:0] range_size;
  logic [SLOT_BITS-1:0] free_total;
  res_status_t          res_status;
  logic [SLOT_BITS-1:0] res_granted;

  // APB: always ready; word address selects the register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_RANGE_SIZE);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? APB_DATA_W'(range_size) : '0;

  // result register may load when empty or when its transfer completes now
  assign out_ready = !out_valid || !out_stall;

  ffra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_ready (out_ready),
    .out_load  (out_load),
    .stat      (dp_stat),
    .cmd_o     (dp_cmd)
  );

  ffra_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .cfg_range   (pwdata[SLOT_BITS-1:0]),
    .req_cmd_in  (cmd),
    .req_cnt_in  (slot_count),
    .req_off_in  (release_offset),
    .cmd_i       (dp_cmd),
    .stat        (dp_stat),
    .range_size  (range_size),
    .free_total  (free_total),
    .res_status  (res_status),
    .res_granted (res_granted)
  );

  // hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= res_status;
      granted_offset <= res_granted;
      free_slots     <= free_total;
    end
  end

endmodule

>>> design/ffra_ctrl.sv
// Request sequencer of the range allocator: scans the free list, commits one update.
// Depends on ffra_pkg; drives ffra_datapath through command and status structs.
module ffra_ctrl import ffra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_ready,
  output logic       out_load,
  input  ffra_stat_t stat,
  output ffra_cmd_t  cmd_o
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_o      = '0;
    cmd_o.res_code = ST_DONE;
    out_load   = 1'b0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load_req = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.is_release) begin
          if (stat.scan_end) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = ST_NO_FIT;
            state_next     = S_FINISH;
          end else if (stat.alloc_hit) begin
            cmd_o.alloc_take = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_code   = ST_DONE;
            state_next       = S_FINISH;
          end else begin
            cmd_o.step = 1'b1;
          end
        end else if (stat.cnt_zero) begin
          // empty release: nothing changes
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_DONE;
          state_next     = S_FINISH;
        end else if (stat.scan_end || stat.ins_hit) begin
          cmd_o.rel_mark = 1'b1;
          state_next     = S_MERGE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_MERGE: begin
        cmd_o.set_res = 1'b1;
        if (stat.merge_none && stat.list_full) begin
          cmd_o.res_code = ST_LIST_FULL;
        end else begin
          cmd_o.rel_commit = 1'b1;
          cmd_o.res_code   = ST_DONE;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/ffra_datapath.sv
// Free-list storage, request registers and merge/split arithmetic of the allocator.
// Depends on ffra_pkg; sequenced by ffra_ctrl.
module ffra_datapath import ffra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  logic [SLOT_BITS-1:0] cfg_range,
  input  logic                 req_cmd_in,
  input  logic [SLOT_BITS-1:0] req_cnt_in,
  input  logic [SLOT_BITS-1:0] req_off_in,
  input  ffra_cmd_t            cmd_i,
  output ffra_stat_t           stat,
  output logic [SLOT_BITS-1:0] range_size,
  output logic [SLOT_BITS-1:0] free_total,
  output res_status_t          res_status,
  output logic [SLOT_BITS-1:0] res_granted
);

  logic [SLOT_BITS-1:0] blk_start [MAX_FREE_BLOCKS];
  logic [SLOT_BITS-1:0] blk_len   [MAX_FREE_BLOCKS];
  logic [SLOT_BITS-1:0] up_start  [MAX_FREE_BLOCKS];
  logic [SLOT_BITS-1:0] up_len    [MAX_FREE_BLOCKS];
  logic [SLOT_BITS-1:0] dn_start  [MAX_FREE_BLOCKS];
  logic [SLOT_BITS-1:0] dn_len    [MAX_FREE_BLOCKS];

  logic [CNT_W-1:0]     n_used;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     ins;
  logic                 req_cmd;
  logic [SLOT_BITS-1:0] req_cnt;
  logic [SLOT_BITS-1:0] req_off;
  logic [SLOT_BITS:0]   prev_end;
  logic [SLOT_BITS-1:0] prev_len;
  logic [SLOT_BITS-1:0] cur_len;
  logic                 left_q;
  logic                 right_q;

  logic [SLOT_BITS-1:0] rd_start;
  logic [SLOT_BITS-1:0] rd_len;
  logic                 exact;
  logic                 left_now;
  logic                 right_now;
  logic [CNT_W-1:0]     ins_m1;
  logic [SLOT_BITS-1:0] len_left;
  logic [SLOT_BITS-1:0] len_both;
  logic [SLOT_BITS-1:0] len_right;

  // neighbor taps used by the compact and open-gap moves
  for (genvar g = 0; g < MAX_FREE_BLOCKS; g++) begin : g_taps
    if (g < MAX_FREE_BLOCKS - 1) begin : g_up
      assign up_start[g] = blk_start[g+1];
      assign up_len[g]   = blk_len[g+1];
    end else begin : g_up_last
      assign up_start[g] = blk_start[g];
      assign up_len[g]   = blk_len[g];
    end
    if (g > 0) begin : g_dn
      assign dn_start[g] = blk_start[g-1];
      assign dn_len[g]   = blk_len[g-1];
    end else begin : g_dn_first
      assign dn_start[g] = blk_start[g];
      assign dn_len[g]   = blk_len[g];
    end
  end

  assign rd_start  = blk_start[idx[IDX_W-1:0]];
  assign rd_len    = blk_len[idx[IDX_W-1:0]];
  assign exact     = (req_cnt == rd_len);
  assign left_now  = (idx != '0) && (prev_end == {1'b0, req_off});
  assign right_now = !stat.scan_end &&
                     (({1'b0, req_off} + {1'b0, req_cnt}) == {1'b0, rd_start});
  assign ins_m1    = ins - CNT_W'(1);
  assign len_left  = sat_add(prev_len, req_cnt);
  assign len_both  = sat_add(len_left, cur_len);
  assign len_right = sat_add(cur_len, req_cnt);

  assign stat.is_release = req_cmd;
  assign stat.cnt_zero   = (req_cnt == '0);
  assign stat.scan_end   = (idx == n_used);
  assign stat.alloc_hit  = (req_cnt <= rd_len);
  assign stat.ins_hit    = (req_off < rd_start);
  assign stat.list_full  = (n_used == CNT_W'(MAX_FREE_BLOCKS));
  assign stat.merge_none = !left_q && !right_q;

  // request and scan registers
  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      req_cmd     <= req_cmd_in;
      req_cnt     <= req_cnt_in;
      req_off     <= req_off_in;
      idx         <= '0;
      res_granted <= '0;
    end else if (cmd_i.step) begin
      idx      <= idx + CNT_W'(1);
      prev_end <= {1'b0, rd_start} + {1'b0, rd_len};
      prev_len <= rd_len;
    end
    if (cmd_i.alloc_take) begin
      res_granted <= rd_start;
    end
    if (cmd_i.rel_mark) begin
      ins     <= idx;
      left_q  <= left_now;
      right_q <= right_now;
      cur_len <= rd_len;
    end
    if (cmd_i.set_res) begin
      res_status <= cmd_i.res_code;
    end
  end

  // range register, list count and free total
  always_ff @(posedge clk) begin
    if (rst) begin
      range_size <= RANGE_RESET;
      n_used     <= CNT_W'(1);
      free_total <= RANGE_RESET;
    end else if (cfg_wr) begin
      range_size <= cfg_range;
      n_used     <= (cfg_range != '0) ? CNT_W'(1) : '0;
      free_total <= cfg_range;
    end else if (cmd_i.alloc_take) begin
      if (exact) begin
        n_used <= n_used - CNT_W'(1);
      end
      free_total <= (req_cnt > free_total) ? '0 : free_total - req_cnt;
    end else if (cmd_i.rel_commit) begin
      if (left_q && right_q) begin
        n_used <= n_used - CNT_W'(1);
      end else if (!left_q && !right_q) begin
        n_used <= n_used + CNT_W'(1);
      end
      free_total <= sat_add(free_total, req_cnt);
    end
  end

  // free-list entries: one write point plus whole-list compact or open-gap moves
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_FREE_BLOCKS; k++) begin
      if (rst || cfg_wr) begin
        if (k == 0) begin
          blk_start[k] <= '0;
          blk_len[k]   <= rst ? RANGE_RESET : cfg_range;
        end
      end else if (cmd_i.alloc_take) begin
        if (exact) begin
          if (CNT_W'(k) >= idx) begin
            blk_start[k] <= up_start[k];
            blk_len[k]   <= up_len[k];
          end
        end else if (CNT_W'(k) == idx) begin
          blk_start[k] <= rd_start + req_cnt;
          blk_len[k]   <= rd_len - req_cnt;
        end
      end else if (cmd_i.rel_commit) begin
        if (left_q && right_q) begin
          if (CNT_W'(k) == ins_m1) begin
            blk_len[k] <= len_both;
          end else if (CNT_W'(k) >= ins) begin
            blk_start[k] <= up_start[k];
            blk_len[k]   <= up_len[k];
          end
        end else if (left_q) begin
          if (CNT_W'(k) == ins_m1) begin
            blk_len[k] <= len_left;
          end
        end else if (right_q) begin
          if (CNT_W'(k) == ins) begin
            blk_start[k] <= req_off;
            blk_len[k]   <= len_right;
          end
        end else begin
          if (CNT_W'(k) == ins) begin
            blk_start[k] <= req_off;
            blk_len[k]   <= req_cnt;
          end else if (CNT_W'(k) > ins) begin
            blk_start[k] <= dn_start[k];
            blk_len[k]   <= dn_len[k];
          end
        end
      end
    end
  end

endmodule
